/* rtl/tbp_pkg.sv */
// tbp_pkg: shared types, counter codes and helpers of the tournament branch predictor
// used by the top level, tbp_slot_mod and tbp_decide; depends on nothing
`default_nettype none

package tbp_pkg;

   localparam int PC_WIDTH                    = 16;
   localparam int TABLE_ENTRIES_DEFAULT       = 1024;
   localparam int LOCAL_HISTORY_COUNT_DEFAULT = 128;

   // 2-bit saturating counter states
   typedef logic [1:0] ctr_type;
   localparam ctr_type CTR_STRONG_NOT = 2'b00;
   localparam ctr_type CTR_WEAK_NOT   = 2'b01;
   localparam ctr_type CTR_WEAK_T     = 2'b10;
   localparam ctr_type CTR_STRONG_T   = 2'b11;

   typedef enum logic [1:0] {
      KIND_ALWAYS     = 2'd0,
      KIND_LOCAL      = 2'd1,
      KIND_GSHARE     = 2'd2,
      KIND_TOURNAMENT = 2'd3
   } kind_type;

   typedef struct packed {
      logic [PC_WIDTH-1:0] pc_low;
      logic                taken;
   } req_type;

   typedef struct packed {
      logic predicted_taken;
      logic prediction_correct;
      logic used_global;
   } rsp_type;

   typedef struct packed {
      logic    predicted;
      logic    correct;
      logic    use_global;
      logic    train_local;
      logic    train_gshare;
      logic    train_chooser;
      ctr_type local_next;
      ctr_type gshare_next;
      ctr_type chooser_next;
   } decide_type;

   function automatic ctr_type ctr_bump(input ctr_type c, input logic t);
      ctr_type r;
      r = c;
      if (t) begin
         if (c != CTR_STRONG_T) r = c + 2'd1;
      end else begin
         if (c != CTR_STRONG_NOT) r = c - 2'd1;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* rtl/tournament_branch_predictor_unit.sv */
// tournament_branch_predictor_unit: local / gshare / chooser branch predictor top level
// depends on tbp_pkg, tbp_slot_mod, tbp_table, tbp_decide
//
//  channel | ports                              | direction | moves
//  --------+------------------------------------+-----------+------------------------------
//  req     | req_valid, req_stall, req_payload  | in        | one branch: pc_low, taken
//  rsp     | rsp_valid, rsp_stall, rsp_payload  | out       | prediction, correct, used_global
//  csr     | csr_valid, csr_ready, csr_wdata    | in        | predictor_kind write
//
// one transaction per cycle sustained unless clearing or rsp_stall holds it; each result passes the
// input register, slot remainder, history read, counter read and result register
// reset starts a clearing pass over max(TABLE_ENTRIES, LOCAL_HISTORY_COUNT) addresses that
// loads counters with strongly taken and histories with zero; req_stall is high meanwhile
// the whole pipeline freezes while the result register holds an untaken transaction;
// read-after-write between neighboring branches is covered by forwarding
`default_nettype none

module tournament_branch_predictor_unit #(
   parameter int TABLE_ENTRIES       = tbp_pkg::TABLE_ENTRIES_DEFAULT,
   parameter int LOCAL_HISTORY_COUNT = tbp_pkg::LOCAL_HISTORY_COUNT_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tbp_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tbp_pkg::rsp_type rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_wdata
);
   import tbp_pkg::*;

   localparam int TW    = $clog2(TABLE_ENTRIES);
   localparam int LW    = $clog2(LOCAL_HISTORY_COUNT);
   localparam int SWEEP = (TABLE_ENTRIES > LOCAL_HISTORY_COUNT) ?
                          TABLE_ENTRIES : LOCAL_HISTORY_COUNT;
   localparam int CW    = $clog2(SWEEP);

   // fold a doubled history or a xor-ed index back under the table size
   function automatic logic [TW-1:0] fold(input logic [TW:0] v);
      logic [TW:0] r;
      r = v;
      if (v >= (TW+1)'(TABLE_ENTRIES)) r = v - (TW+1)'(TABLE_ENTRIES);
      return r[TW-1:0];
   endfunction

   // control state
   logic          clearing_ff;
   logic [CW-1:0] clr_cnt_ff;
   kind_type      kind_ff;
   logic [TW-1:0] ghist_ff;
   logic          va_ff, vb_ff, vc_ff, vd_ff;
   logic          rsp_valid_ff;

   // pipeline payload
   logic [PC_WIDTH-1:0] pca_ff;
   logic                ta_ff, tb_ff, tc_ff, td_ff;
   logic [TW-1:0]       cslot_b;
   logic [LW-1:0]       lslot_b;
   logic [TW-1:0]       cslot_c_ff, cslot_d_ff;
   logic [LW-1:0]       lslot_c_ff, lslot_d_ff;
   logic [TW-1:0]       lidx_d_ff, gidx_d_ff;
   rsp_type             rsp_ff;

   logic          adv;
   logic          accept;
   logic          clr_hist_en;
   logic          clr_tab_en;
   logic [TW-1:0] hist_rd;
   logic [TW-1:0] hist_new_d;
   logic          hist_fwd;
   logic [TW-1:0] lidx_c;
   logic [TW-1:0] ghist_in;
   logic [TW-1:0] ghist_eff;
   logic [TW-1:0] gidx_c;
   ctr_type       lctr_rd, gctr_rd, chooser_rd;
   decide_type    dec;

   logic          hist_we, lctr_we, gctr_we, chooser_we;
   logic [LW-1:0] hist_waddr;
   logic [TW-1:0] hist_wdata;
   logic [TW-1:0] lctr_waddr, gctr_waddr, chooser_waddr;
   ctr_type       lctr_wdata, gctr_wdata, chooser_wdata;

   // handshakes: everything moves when the result register is free or being taken
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = clearing_ff || !adv;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // clearing pass bounds
   assign clr_hist_en = clearing_ff && ({1'b0, clr_cnt_ff} < (CW+1)'(LOCAL_HISTORY_COUNT));
   assign clr_tab_en  = clearing_ff && ({1'b0, clr_cnt_ff} < (CW+1)'(TABLE_ENTRIES));

   // stage b: slot remainders of the registered address
   tbp_slot_mod #(.DIVISOR(TABLE_ENTRIES)) u_cslot (
      .clock  (clock),
      .enable (adv),
      .value  (pca_ff),
      .slot   (cslot_b)
   );

   tbp_slot_mod #(.DIVISOR(LOCAL_HISTORY_COUNT)) u_lslot (
      .clock  (clock),
      .enable (adv),
      .value  (pca_ff),
      .slot   (lslot_b)
   );

   // local history table, read in stage b, data in stage c
   tbp_table #(.DEPTH(LOCAL_HISTORY_COUNT), .WIDTH(TW)) u_hist (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (adv),
      .rd_addr (lslot_b),
      .rd_data (hist_rd),
      .wr_en   (hist_we),
      .wr_addr (hist_waddr),
      .wr_data (hist_wdata)
   );

   // stage c: forward the history the stage d branch is about to write
   assign hist_new_d = fold({lidx_d_ff, td_ff});
   assign hist_fwd   = vd_ff && dec.train_local && (lslot_d_ff == lslot_c_ff);
   assign lidx_c     = hist_fwd ? hist_new_d : hist_rd;

   // global history as it will stand once the stage d branch retires
   assign ghist_in  = fold({ghist_ff, td_ff});
   assign ghist_eff = (vd_ff && dec.train_gshare) ? ghist_in : ghist_ff;
   assign gidx_c    = fold({1'b0, cslot_c_ff ^ ghist_eff});

   // counter tables, read in stage c, data in stage d
   tbp_table #(.DEPTH(TABLE_ENTRIES), .WIDTH(2)) u_lctr (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (adv),
      .rd_addr (lidx_c),
      .rd_data (lctr_rd),
      .wr_en   (lctr_we),
      .wr_addr (lctr_waddr),
      .wr_data (lctr_wdata)
   );

   tbp_table #(.DEPTH(TABLE_ENTRIES), .WIDTH(2)) u_gctr (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (adv),
      .rd_addr (gidx_c),
      .rd_data (gctr_rd),
      .wr_en   (gctr_we),
      .wr_addr (gctr_waddr),
      .wr_data (gctr_wdata)
   );

   tbp_table #(.DEPTH(TABLE_ENTRIES), .WIDTH(2)) u_chooser (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (adv),
      .rd_addr (cslot_c_ff),
      .rd_data (chooser_rd),
      .wr_en   (chooser_we),
      .wr_addr (chooser_waddr),
      .wr_data (chooser_wdata)
   );

   // stage d: predict and work out the training writes
   tbp_decide u_decide (
      .kind        (kind_ff),
      .taken       (td_ff),
      .local_ctr   (lctr_rd),
      .gshare_ctr  (gctr_rd),
      .chooser_ctr (chooser_rd),
      .decide      (dec)
   );

   // write ports: clearing pass right after reset, training afterwards
   always_comb begin
      if (clearing_ff) begin
         hist_we       = clr_hist_en;
         hist_waddr    = clr_cnt_ff[LW-1:0];
         hist_wdata    = '0;
         lctr_we       = clr_tab_en;
         gctr_we       = clr_tab_en;
         chooser_we    = clr_tab_en;
         lctr_waddr    = clr_cnt_ff[TW-1:0];
         gctr_waddr    = clr_cnt_ff[TW-1:0];
         chooser_waddr = clr_cnt_ff[TW-1:0];
         lctr_wdata    = CTR_STRONG_T;
         gctr_wdata    = CTR_STRONG_T;
         chooser_wdata = CTR_STRONG_T;
      end else begin
         hist_we       = adv && vd_ff && dec.train_local;
         hist_waddr    = lslot_d_ff;
         hist_wdata    = hist_new_d;
         lctr_we       = adv && vd_ff && dec.train_local;
         gctr_we       = adv && vd_ff && dec.train_gshare;
         chooser_we    = adv && vd_ff && dec.train_chooser;
         lctr_waddr    = lidx_d_ff;
         gctr_waddr    = gidx_d_ff;
         chooser_waddr = cslot_d_ff;
         lctr_wdata    = dec.local_next;
         gctr_wdata    = dec.gshare_next;
         chooser_wdata = dec.chooser_next;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clr_cnt_ff   <= '0;
         kind_ff      <= KIND_ALWAYS;
         ghist_ff     <= '0;
         va_ff        <= 1'b0;
         vb_ff        <= 1'b0;
         vc_ff        <= 1'b0;
         vd_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (clearing_ff) begin
            clr_cnt_ff <= clr_cnt_ff + CW'(1);
            if (clr_cnt_ff == CW'(SWEEP - 1)) clearing_ff <= 1'b0;
         end
         if (csr_valid) kind_ff <= kind_type'(csr_wdata);
         if (adv) begin
            va_ff        <= accept;
            vb_ff        <= va_ff;
            vc_ff        <= vb_ff;
            vd_ff        <= vc_ff;
            rsp_valid_ff <= vd_ff;
            if (vd_ff && dec.train_gshare) ghist_ff <= ghist_in;
         end
      end
   end

   // pipeline payload registers
   always_ff @(posedge clock) begin
      if (adv) begin
         pca_ff     <= req_payload.pc_low;
         ta_ff      <= req_payload.taken;
         tb_ff      <= ta_ff;
         tc_ff      <= tb_ff;
         td_ff      <= tc_ff;
         cslot_c_ff <= cslot_b;
         lslot_c_ff <= lslot_b;
         cslot_d_ff <= cslot_c_ff;
         lslot_d_ff <= lslot_c_ff;
         lidx_d_ff  <= lidx_c;
         gidx_d_ff  <= gidx_c;
         rsp_ff.predicted_taken    <= dec.predicted;
         rsp_ff.prediction_correct <= dec.correct;
         rsp_ff.used_global        <= dec.use_global;
      end
   end

endmodule

`default_nettype wire

/* rtl/tbp_slot_mod.sv */
// tbp_slot_mod: registered branch address and its remainder by a constant table size
// depends on tbp_pkg
`default_nettype none

module tbp_slot_mod #(
   parameter int DIVISOR = 2
) (
   input  logic                           clock,
   input  logic                           enable,
   input  logic [tbp_pkg::PC_WIDTH-1:0]   value,
   output logic [$clog2(DIVISOR)-1:0]     slot
);
   import tbp_pkg::*;

   localparam int SW = $clog2(DIVISOR);

   generate
      if ((DIVISOR & (DIVISOR - 1)) == 0) begin : g_pow2
         // only the low address bits matter for a power-of-two table
         logic [SW-1:0] low_ff;

         always_ff @(posedge clock) begin
            if (enable) low_ff <= value[SW-1:0];
         end
         assign slot = low_ff;
      end else begin : g_recip
         // quotient estimate by reciprocal, low by at most one
         localparam logic [31:0] RECIP = 32'((64'd1 << 32) / DIVISOR);
         logic [PC_WIDTH-1:0] value_ff;
         logic [47:0]         prod;
         logic [PC_WIDTH-1:0] quot_ff;
         logic [32:0]         qt;
         logic [16:0]         rem;
         logic [16:0]         rem_fix;

         assign prod = 48'(value) * 48'(RECIP);

         always_ff @(posedge clock) begin
            if (enable) begin
               value_ff <= value;
               quot_ff  <= prod[47:32];
            end
         end

         assign qt      = 33'(quot_ff) * 33'(DIVISOR);
         assign rem     = 17'(value_ff) - qt[16:0];
         assign rem_fix = (rem >= 17'(DIVISOR)) ? rem - 17'(DIVISOR) : rem;
         assign slot    = rem_fix[SW-1:0];
      end
   endgenerate

endmodule

`default_nettype wire

/* rtl/tbp_table.sv */
// tbp_table: one-write one-read table with registered read and last-write bypass
// depends on nothing (no tbp_pkg types used)
`default_nettype none

module tbp_table #(
   parameter int DEPTH = 2,
   parameter int WIDTH = 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);

   localparam int AW = $clog2(DEPTH);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_ff;
   logic [AW-1:0]    raddr_ff;
   logic             lw_valid_ff;
   logic [AW-1:0]    lw_addr_ff;
   logic [WIDTH-1:0] lw_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) begin
         rd_ff      <= mem[rd_addr];
         raddr_ff   <= rd_addr;
         lw_addr_ff <= wr_addr;
         lw_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lw_valid_ff <= 1'b0;
      end else if (rd_en) begin
         lw_valid_ff <= wr_en;
      end
   end

   // a write on the same edge as the read is not seen by the array read
   assign rd_data = (lw_valid_ff && (lw_addr_ff == raddr_ff)) ? lw_data_ff : rd_ff;

endmodule

`default_nettype wire

/* rtl/tbp_decide.sv */
// tbp_decide: prediction choice and training values for one branch
// depends on tbp_pkg
`default_nettype none

module tbp_decide (
   input  tbp_pkg::kind_type   kind,
   input  logic                taken,
   input  tbp_pkg::ctr_type    local_ctr,
   input  tbp_pkg::ctr_type    gshare_ctr,
   input  tbp_pkg::ctr_type    chooser_ctr,
   output tbp_pkg::decide_type decide
);
   import tbp_pkg::*;

   logic    lp;
   logic    gp;
   logic    lc;
   logic    gc;
   ctr_type ch_next;

   assign lp = local_ctr[1];
   assign gp = gshare_ctr[1];
   assign lc = (lp == taken);
   assign gc = (gp == taken);

   always_comb begin
      case (chooser_ctr)
         CTR_STRONG_T: ch_next = (!gc && lc) ? CTR_WEAK_T : CTR_STRONG_T;
         CTR_WEAK_T:   ch_next = gc ? CTR_STRONG_T : (lc ? CTR_WEAK_NOT : CTR_WEAK_T);
         CTR_WEAK_NOT: ch_next = lc ? CTR_STRONG_NOT : (gc ? CTR_WEAK_T : CTR_WEAK_NOT);
         default:      ch_next = (!lc && gc) ? CTR_WEAK_NOT : CTR_STRONG_NOT;
      endcase
   end

   always_comb begin
      decide               = '0;
      decide.local_next    = ctr_bump(local_ctr, taken);
      decide.gshare_next   = ctr_bump(gshare_ctr, taken);
      decide.chooser_next  = ch_next;
      unique case (kind)
         KIND_ALWAYS: begin
            decide.predicted = 1'b1;
         end
         KIND_LOCAL: begin
            decide.predicted   = lp;
            decide.train_local = 1'b1;
         end
         KIND_GSHARE: begin
            decide.predicted    = gp;
            decide.train_gshare = 1'b1;
         end
         KIND_TOURNAMENT: begin
            decide.use_global    = chooser_ctr[1];
            decide.predicted     = chooser_ctr[1] ? gp : lp;
            decide.train_local   = 1'b1;
            decide.train_gshare  = 1'b1;
            decide.train_chooser = 1'b1;
         end
      endcase
      decide.correct = (decide.predicted == taken);
   end

endmodule

`default_nettype wire
